/* rtl/hbs_pkg.sv */
`default_nettype none

package hbs_pkg;

    // Default side of the square height store, in texels.
    localparam int MAX_SIDE_DEF = 256;

    // Q1.16 fixed point
    localparam int          Q16_W   = 17;
    localparam logic [16:0] ONE_Q16 = 17'h10000;

    // Field widths
    localparam int TEXEL_W  = 8;
    localparam int HEIGHT_W = 24;
    localparam int CFG_W    = 17;
    localparam int CFG_IDX_W = 2;
    localparam int DIM_W    = 9;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TAP_OFFSET  = 2'd2;

    // Register reset values
    localparam logic [DIM_W-1:0] GRID_WIDTH_RST  = 9'd256;
    localparam logic [DIM_W-1:0] GRID_HEIGHT_RST = 9'd256;
    localparam logic [CFG_W-1:0] TAP_OFFSET_RST  = 17'd256;

    typedef enum logic [1:0] {
        OP_WRITE   = 2'd0,
        OP_SAMPLE  = 2'd1,
        OP_AVERAGE = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCALE,
        S_READ,
        S_ROWS,
        S_COL,
        S_DONE
    } t_state;

    // Saturate a Q1.16 value to 1.0
    function automatic logic [Q16_W-1:0] sat_q16(input logic [Q16_W-1:0] x);
        logic [Q16_W-1:0] y;
        y = (x > ONE_Q16) ? ONE_Q16 : x;
        return y;
    endfunction

endpackage

`default_nettype wire

/* rtl/hbs_store.sv */
`default_nettype none

module hbs_store
    import hbs_pkg::*;
#(
    parameter int ADDR_W = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_we,
    input  wire logic [ADDR_W-1:0]  i_waddr,
    input  wire logic [TEXEL_W-1:0] i_wdata,
    input  wire logic               i_re,
    input  wire logic [ADDR_W-1:0]  i_raddr,
    output logic      [TEXEL_W-1:0] o_rdata
);

    // Height texel memory with one write port and one read port, registered read.
    logic [TEXEL_W-1:0] mem [2**ADDR_W];
    logic [TEXEL_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* rtl/heightmap_bilinear_sampler_top.sv */
`default_nettype none

// Channel   Direction  Handshake                     Payload
// in        sink       i_in_valid / o_in_ready       i_operation, i_texel_row, i_texel_col,
//                                                    i_texel_value, i_coord_u, i_coord_v
// out       source     o_out_valid / i_out_ready     o_height_value
// cfg       sink       i_cfg_we (no wait)            i_cfg_index, i_cfg_data
//
// A texel write is taken in S_IDLE and leaves the FSM there. A bilinear sample holds the input
// while it runs S_SCALE, S_READ, S_ROWS and S_COL, then loads its result from S_DONE.
// An averaged sample runs S_SCALE to S_COL once for each of its 4 taps before S_DONE.
// Each tap is bound by four reads through the store's one read port.
// Reset clears control state and registers; the texel store is not cleared.
// A result waiting on the output does not block the next transfer in; a
// finished sample waits in S_DONE only while the output register is still full.

module heightmap_bilinear_sampler_top
    import hbs_pkg::*;
#(
    parameter int MAX_SIDE = MAX_SIDE_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // input item channel
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic [1:0]           i_operation,
    input  wire logic [7:0]           i_texel_row,
    input  wire logic [7:0]           i_texel_col,
    input  wire logic [TEXEL_W-1:0]   i_texel_value,
    input  wire logic [Q16_W-1:0]     i_coord_u,
    input  wire logic [Q16_W-1:0]     i_coord_v,
    // result channel
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic [HEIGHT_W-1:0]       o_height_value,
    // configuration write port
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data
);

    localparam int SIDE_W  = $clog2(MAX_SIDE);   // bits of a row or column index
    localparam int ADDR_W  = 2 * SIDE_W;         // store address = {row, col}
    localparam int FX_W    = 16 + SIDE_W;        // scaled coordinate, Q.16
    localparam int POS_W   = 9;                  // 8-bit field index, one spare bit
    localparam int CMP_W   = (SIDE_W + 1 > POS_W) ? SIDE_W + 1 : POS_W;
    localparam int ROW_W   = HEIGHT_W + 1;       // one row blend plus carry
    localparam int COL_W   = HEIGHT_W + Q16_W;   // column blend before >> 16
    localparam int SUM_W   = HEIGHT_W + 2;       // four samples

    // ---------------- configuration ----------------
    logic [DIM_W-1:0] r_grid_width;
    logic [DIM_W-1:0] r_grid_height;
    logic [CFG_W-1:0] r_tap_offset;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= GRID_WIDTH_RST;
            r_grid_height <= GRID_HEIGHT_RST;
            r_tap_offset  <= TAP_OFFSET_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_GRID_WIDTH:  r_grid_width  <= i_cfg_data[DIM_W-1:0];
                CFG_GRID_HEIGHT: r_grid_height <= i_cfg_data[DIM_W-1:0];
                CFG_TAP_OFFSET:  r_tap_offset  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // last column / row in use, with size clamped to 1..MAX_SIDE
    logic [SIDE_W-1:0] w_m1;
    logic [SIDE_W-1:0] h_m1;

    always_comb begin
        if (r_grid_width == '0) begin
            w_m1 = '0;
        end else if (32'(r_grid_width) > MAX_SIDE) begin
            w_m1 = SIDE_W'(MAX_SIDE - 1);
        end else begin
            w_m1 = SIDE_W'(r_grid_width - 9'd1);
        end
        if (r_grid_height == '0) begin
            h_m1 = '0;
        end else if (32'(r_grid_height) > MAX_SIDE) begin
            h_m1 = SIDE_W'(MAX_SIDE - 1);
        end else begin
            h_m1 = SIDE_W'(r_grid_height - 9'd1);
        end
    end

    // ---------------- input transfer ----------------
    t_state r_state, n_state;
    logic   in_xfer;
    logic   is_write, is_sample, is_avg;
    logic   wr_in_range;

    assign in_xfer   = i_in_valid && o_in_ready;
    assign is_write  = (i_operation == OP_WRITE);
    assign is_sample = (i_operation == OP_SAMPLE);
    assign is_avg    = (i_operation == OP_AVERAGE);

    // writes beyond the store are dropped
    assign wr_in_range = (CMP_W'(i_texel_row) < CMP_W'(MAX_SIDE)) &&
                         (CMP_W'(i_texel_col) < CMP_W'(MAX_SIDE));

    logic [Q16_W-1:0] u_sat, v_sat, d_sat;
    assign u_sat = sat_q16(i_coord_u);
    assign v_sat = sat_q16(i_coord_v);
    assign d_sat = sat_q16(r_tap_offset);

    // tap coordinates, latched at transfer
    logic [Q16_W-1:0] r_u, r_v, r_um, r_vm;
    logic             r_avg;

    always_ff @(posedge i_clk) begin
        if (in_xfer && (is_sample || is_avg)) begin
            r_u  <= u_sat;
            r_v  <= v_sat;
            r_um <= (u_sat > d_sat) ? u_sat - d_sat : '0;   // negative clamps to 0
            r_vm <= (v_sat > d_sat) ? v_sat - d_sat : '0;
        end
    end

    // ---------------- tap sequencing ----------------
    logic [1:0] r_tap;
    logic [2:0] r_k;         // read step: 0..3 issue, 1..4 capture
    logic       last_tap;

    assign last_tap = !r_avg || (r_tap == 2'd3);

    // taps: (u,v), (u-d,v-d), (u,v-d), (u-d,v)
    logic [Q16_W-1:0] tap_u, tap_v;
    assign tap_u = (r_tap == 2'd1 || r_tap == 2'd3) ? r_um : r_u;
    assign tap_v = (r_tap == 2'd1 || r_tap == 2'd2) ? r_vm : r_v;

    // scale into cell index and fraction
    logic [FX_W-1:0] r_fx, r_fy;

    always_ff @(posedge i_clk) begin
        if (r_state == S_SCALE) begin
            r_fx <= FX_W'(tap_u) * FX_W'(w_m1);
            r_fy <= FX_W'(tap_v) * FX_W'(h_m1);
        end
    end

    logic [SIDE_W-1:0] lx, ly, hx, hy;
    assign lx = r_fx[FX_W-1:16];      // never beyond w-1 since u <= 1.0
    assign ly = r_fy[FX_W-1:16];
    assign hx = (lx == w_m1) ? lx : lx + 1'b1;
    assign hy = (ly == h_m1) ? ly : ly + 1'b1;

    // ---------------- store ----------------
    logic              mem_we, mem_re;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr;
    logic [TEXEL_W-1:0] mem_rdata;

    // writes only happen in S_IDLE, reads only in S_READ: no overlap on an entry
    assign mem_we    = in_xfer && is_write && wr_in_range;
    assign mem_waddr = {SIDE_W'(i_texel_row), SIDE_W'(i_texel_col)};

    always_comb begin
        unique case (r_k[1:0])
            2'd0: mem_raddr = {ly, lx};
            2'd1: mem_raddr = {ly, hx};
            2'd2: mem_raddr = {hy, lx};
            2'd3: mem_raddr = {hy, hx};
            default: mem_raddr = {ly, lx};
        endcase
    end

    hbs_store #(
        .ADDR_W (ADDR_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (i_texel_value),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // corner texels: LL, LR, HL, HR
    logic [TEXEL_W-1:0] r_tex [4];
    logic [1:0]         cap_idx;
    assign cap_idx = 2'(r_k - 3'd1);

    always_ff @(posedge i_clk) begin
        if (r_state == S_READ && r_k != 3'd0) begin
            r_tex[cap_idx] <= mem_rdata;
        end
    end

    // ---------------- blend ----------------
    logic [15:0]      frac_a, frac_b;
    logic [Q16_W-1:0] inv_a, inv_b;
    logic [ROW_W-1:0] top_sum, bot_sum;
    logic [HEIGHT_W-1:0] r_top, r_bot;
    logic [COL_W-1:0] col_sum;
    logic [HEIGHT_W-1:0] tap_height;

    assign frac_a = r_fx[15:0];
    assign frac_b = r_fy[15:0];
    assign inv_a  = ONE_Q16 - Q16_W'(frac_a);
    assign inv_b  = ONE_Q16 - Q16_W'(frac_b);

    assign top_sum = ROW_W'(r_tex[0]) * ROW_W'(inv_a) + ROW_W'(r_tex[1]) * ROW_W'(frac_a);
    assign bot_sum = ROW_W'(r_tex[2]) * ROW_W'(inv_a) + ROW_W'(r_tex[3]) * ROW_W'(frac_a);

    always_ff @(posedge i_clk) begin
        if (r_state == S_ROWS) begin
            r_top <= top_sum[HEIGHT_W-1:0];   // exact: at most 255 * 65536
            r_bot <= bot_sum[HEIGHT_W-1:0];
        end
    end

    assign col_sum    = COL_W'(r_top) * COL_W'(inv_b) + COL_W'(r_bot) * COL_W'(frac_b);
    assign tap_height = col_sum[16 +: HEIGHT_W];

    logic [SUM_W-1:0] r_sum;

    // ---------------- result register ----------------
    logic                out_free;
    logic                out_load;
    logic [HEIGHT_W-1:0] r_out_data;
    logic                r_out_valid;

    assign out_free = !r_out_valid || i_out_ready;

    // ---------------- FSM ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_xfer && (is_sample || is_avg)) begin
                    n_state = S_SCALE;
                end
            end
            S_SCALE: n_state = S_READ;
            S_READ: begin
                if (r_k == 3'd4) begin
                    n_state = S_ROWS;
                end
            end
            S_ROWS: n_state = S_COL;
            S_COL:  n_state = last_tap ? S_DONE : S_SCALE;
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = (r_state == S_IDLE);
        mem_re     = (r_state == S_READ) && (r_k != 3'd4);
        out_load   = (r_state == S_DONE) && out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_tap       <= '0;
            r_k         <= '0;
            r_avg       <= 1'b0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_xfer) begin
                r_avg <= is_avg;
                r_tap <= '0;
                r_sum <= '0;
            end
            if (r_state == S_SCALE) begin
                r_k <= '0;
            end else if (r_state == S_READ) begin
                r_k <= r_k + 3'd1;
            end
            if (r_state == S_COL) begin
                r_sum <= r_sum + SUM_W'(tap_height);
                r_tap <= r_tap + 2'd1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_data <= r_avg ? r_sum[SUM_W-1:2] : r_sum[HEIGHT_W-1:0];
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_height_value = r_out_data;

    // ---------------- assertions ----------------
    // fetch addresses stay inside the grid in use
    a_addr_in_grid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> (hx <= w_m1) && (hy <= h_m1) && (lx <= w_m1) && (ly <= h_m1))
        else $error("texel fetch outside grid");

    // no store write while a sample is reading
    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mem_we && mem_re))
        else $error("store write during sample read");

    // a sample transfer blocks the input until it finishes
    a_busy_after_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && (is_sample || is_avg)) |=> !o_in_ready)
        else $error("input ready during sample");

    // a loaded result shows up as valid next cycle
    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> o_out_valid)
        else $error("result lost");

    // read step counter never runs past the last capture
    a_k_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> (r_k <= 3'd4))
        else $error("read step overrun");

endmodule

`default_nettype wire
